[hdl/golomb_rice_set_decoder_top_defines.svh]
// assertion macros for the golomb-rice coded set decoder
// used by golomb_rice_set_decoder_top, expects clk and rst_n in scope
`ifndef GOLOMB_RICE_SET_DECODER_TOP_DEFINES_SVH
`define GOLOMB_RICE_SET_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define GRSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define GRSD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRSD_ASSERT(lbl, prop, msg)
`define GRSD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[hdl/grsd_pkg.sv]
// types and constants for the golomb-rice coded set decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package grsd_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_END
    } state_t;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_UNARY,
        PH_REMAIN
    } phase_t;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_KEY    = 2'd1;
    localparam logic [1:0] KIND_OK     = 2'd2;
    localparam logic [1:0] KIND_ERR    = 2'd3;

    localparam int HEADER_BITS = 10;
    localparam int LOG_BITS    = 5;
    localparam int KEY_BITS    = 64;
    localparam int QUOT_BITS   = 32;

    typedef struct packed {
        logic [1:0]          kind;
        logic [KEY_BITS-1:0] key_value;
        logic [LOG_BITS-1:0] header_log_count;
        logic [LOG_BITS-1:0] header_log_p;
    } result_t;

endpackage

`default_nettype wire

[hdl/grsd_in_if.sv]
// input byte channel of the golomb-rice coded set decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface grsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[hdl/grsd_out_if.sv]
// result channel of the golomb-rice coded set decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface grsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] key_value;
    logic [4:0]  header_log_count;
    logic [4:0]  header_log_p;
    logic        run_last;

    modport source (
        output valid, output kind, output key_value, output header_log_count,
        output header_log_p, output run_last, input ready
    );
    modport sink (
        input valid, input kind, input key_value, input header_log_count,
        input header_log_p, input run_last, output ready
    );
endinterface

`default_nettype wire

[hdl/golomb_rice_set_decoder_top.sv]
// golomb-rice coded set decoder, bit-serial over each input byte
// depends on grsd_pkg, grsd_in_if, grsd_out_if and golomb_rice_set_decoder_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "golomb_rice_set_decoder_top_defines.svh"

// Decodes a digest byte stream: a 10-bit header (log count, log P), then Rice codewords
// whose deltas plus one are summed from all ones to give sorted 64-bit keys. Each byte is
// shifted through one bit per cycle unless a bit with a result must wait; after the bit
// steps an idle step hands over the held result and takes the next byte, and a final byte
// adds one end step that reports success or error. A result is held back one slot so
// that run_last can be set on the last result of its byte; a bit that produces a result
// waits while that slot is full and the output register is full and not being read.
module golomb_rice_set_decoder_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    grsd_in_if.sink    bytes,
    grsd_out_if.source results
);
    import grsd_pkg::*;

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next, phase_step;
    logic [LOG_BITS-1:0]   bit_count_reg, bit_count_next, bit_count_step;
    logic [HEADER_BITS-1:0] header_shift_reg, header_shift_next, header_shift_step;
    logic [LOG_BITS-1:0]   log_p_reg, log_p_next, log_p_step;
    logic [LOG_BITS-1:0]   log_count_reg, log_count_next, log_count_step;
    logic [KEY_BITS-1:0]   delta_reg, delta_next, delta_step;
    logic [KEY_BITS-1:0]   prev_key_reg, prev_key_next, prev_key_step;
    logic                  started_reg, started_next, started_step;
    logic                  ended_key_reg, ended_key_next, ended_key_step;
    logic [1:0]            byte_index_reg, byte_index_next;
    logic [2:0]            bit_idx_reg, bit_idx_next;
    logic [7:0]            data_reg, data_next;
    logic                  last_reg, last_next;
    logic                  pend_valid_reg, pend_valid_next;
    result_t               pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;
    logic                  out_last_reg, out_last_next;

    logic                  bit_in;
    logic                  out_free;
    logic                  ev;
    result_t               ev_res;
    logic [KEY_BITS-1:0]   delta_in;
    logic [KEY_BITS-1:0]   key_sum;
    logic [HEADER_BITS-1:0] hs_new;
    logic [LOG_BITS-1:0]   bc_inc;
    logic                  push_en;
    result_t               push_res;
    logic                  flush_en;
    logic                  end_ok;
    logic                  blocked;

    assign bit_in   = data_reg[7];
    assign out_free = !out_valid_reg || results.ready;
    assign hs_new   = {header_shift_reg[HEADER_BITS-2:0], bit_in};
    assign bc_inc   = bit_count_reg + LOG_BITS'(1);
    // a remainder bit lands in the delta before the key add
    assign delta_in = (phase_reg == PH_REMAIN) ? {delta_reg[KEY_BITS-2:0], bit_in} : delta_reg;
    assign key_sum  = prev_key_reg + delta_in + KEY_BITS'(1);
    assign blocked  = pend_valid_reg && !out_free;
    assign end_ok   = (byte_index_reg >= 2'd2)
                      && (ended_key_reg || (phase_reg == PH_UNARY && started_reg));

    // work of one bit of the current byte
    always_comb
    begin
        phase_step        = phase_reg;
        bit_count_step    = bit_count_reg;
        header_shift_step = header_shift_reg;
        log_p_step        = log_p_reg;
        log_count_step    = log_count_reg;
        delta_step        = delta_reg;
        prev_key_step     = prev_key_reg;
        started_step      = started_reg;
        ended_key_step    = 1'b0;
        ev                = 1'b0;
        ev_res            = '0;
        unique case (phase_reg)
            PH_HEADER:
            begin
                header_shift_step = hs_new;
                bit_count_step    = bc_inc;
                if (bit_count_reg == LOG_BITS'(HEADER_BITS - 1))
                begin
                    log_count_step   = hs_new[HEADER_BITS-1:LOG_BITS];
                    log_p_step       = hs_new[LOG_BITS-1:0];
                    ev               = 1'b1;
                    ev_res.kind      = KIND_HEADER;
                    ev_res.header_log_count = hs_new[HEADER_BITS-1:LOG_BITS];
                    ev_res.header_log_p     = hs_new[LOG_BITS-1:0];
                    phase_step       = PH_UNARY;
                    delta_step       = '0;
                    bit_count_step   = '0;
                    started_step     = (bit_idx_reg != 3'd7);
                end
            end
            PH_UNARY:
            begin
                if (!bit_in)
                begin
                    // quotient wraps in its own 32 bits
                    delta_step = {delta_reg[KEY_BITS-1:QUOT_BITS],
                                  delta_reg[QUOT_BITS-1:0] + QUOT_BITS'(1)};
                end
                else if (log_p_reg != '0)
                begin
                    phase_step     = PH_REMAIN;
                    bit_count_step = '0;
                end
                else
                begin
                    ev = 1'b1;
                end
            end
            PH_REMAIN:
            begin
                delta_step     = delta_in;
                bit_count_step = bc_inc;
                if (bc_inc >= log_p_reg)
                begin
                    ev = 1'b1;
                end
            end
            default:
            begin
                phase_step = PH_HEADER;
            end
        endcase
        // key complete: add and restart the unary run
        if (ev && phase_reg != PH_HEADER)
        begin
            prev_key_step    = key_sum;
            ev_res.kind      = KIND_KEY;
            ev_res.key_value = key_sum;
            ev_res.header_log_count = log_count_reg;
            ev_res.header_log_p     = log_p_reg;
            ended_key_step   = 1'b1;
            phase_step       = PH_UNARY;
            delta_step       = '0;
            bit_count_step   = '0;
            started_step     = (bit_idx_reg != 3'd7);
        end
    end

    // sequencer, held result and output register
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        header_shift_next = header_shift_reg;
        log_p_next        = log_p_reg;
        log_count_next    = log_count_reg;
        delta_next        = delta_reg;
        prev_key_next     = prev_key_reg;
        started_next      = started_reg;
        ended_key_next    = ended_key_reg;
        byte_index_next   = byte_index_reg;
        bit_idx_next      = bit_idx_reg;
        data_next         = data_reg;
        last_next         = last_reg;
        pend_valid_next   = pend_valid_reg;
        pend_next         = pend_reg;
        out_valid_next    = out_valid_reg && !results.ready;
        out_next          = out_reg;
        out_last_next     = out_last_reg;
        bytes.ready       = 1'b0;
        push_en           = 1'b0;
        push_res          = '0;
        flush_en          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                bytes.ready = !pend_valid_reg || out_free;
                flush_en    = pend_valid_reg && out_free;
                if (bytes.valid && bytes.ready)
                begin
                    data_next    = bytes.data_byte;
                    last_next    = bytes.last_byte;
                    bit_idx_next = '0;
                    started_next = 1'b0;
                    if (byte_index_reg != 2'd3)
                    begin
                        byte_index_next = byte_index_reg + 2'd1;
                    end
                    state_next = ST_BITS;
                end
            end
            ST_BITS:
            begin
                if (!(ev && blocked))
                begin
                    phase_next        = phase_step;
                    bit_count_next    = bit_count_step;
                    header_shift_next = header_shift_step;
                    log_p_next        = log_p_step;
                    log_count_next    = log_count_step;
                    delta_next        = delta_step;
                    prev_key_next     = prev_key_step;
                    started_next      = started_step;
                    ended_key_next    = ended_key_step;
                    data_next         = {data_reg[6:0], 1'b0};
                    bit_idx_next      = bit_idx_reg + 3'd1;
                    push_en           = ev;
                    push_res          = ev_res;
                    if (bit_idx_reg == 3'd7)
                    begin
                        state_next = last_reg ? ST_END : ST_IDLE;
                    end
                end
            end
            ST_END:
            begin
                if (!blocked)
                begin
                    push_en                   = 1'b1;
                    push_res.kind             = end_ok ? KIND_OK : KIND_ERR;
                    push_res.header_log_count = log_count_reg;
                    push_res.header_log_p     = log_p_reg;
                    phase_next        = PH_HEADER;
                    bit_count_next    = '0;
                    header_shift_next = '0;
                    log_p_next        = '0;
                    log_count_next    = '0;
                    delta_next        = '0;
                    prev_key_next     = '1;
                    started_next      = 1'b0;
                    ended_key_next    = 1'b0;
                    byte_index_next   = '0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // the held result is last of its byte only when handed over from idle
        if (flush_en)
        begin
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (push_en)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = push_res;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_HEADER;
            bit_count_reg    <= '0;
            header_shift_reg <= '0;
            log_p_reg        <= '0;
            log_count_reg    <= '0;
            delta_reg        <= '0;
            prev_key_reg     <= '1;
            started_reg      <= 1'b0;
            ended_key_reg    <= 1'b0;
            byte_index_reg   <= '0;
            bit_idx_reg      <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            header_shift_reg <= header_shift_next;
            log_p_reg        <= log_p_next;
            log_count_reg    <= log_count_next;
            delta_reg        <= delta_next;
            prev_key_reg     <= prev_key_next;
            started_reg      <= started_next;
            ended_key_reg    <= ended_key_next;
            byte_index_reg   <= byte_index_next;
            bit_idx_reg      <= bit_idx_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        last_reg     <= last_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign results.valid            = out_valid_reg;
    assign results.kind             = out_reg.kind;
    assign results.key_value        = out_reg.key_value;
    assign results.header_log_count = out_reg.header_log_count;
    assign results.header_log_p     = out_reg.header_log_p;
    assign results.run_last         = out_last_reg;

    `GRSD_ASSERT(a_key_zero, results.valid && results.kind != KIND_KEY |-> results.key_value == 64'd0, "key_value set on a result that is not a key")
    `GRSD_ASSERT(a_end_last, results.valid && (results.kind == KIND_OK || results.kind == KIND_ERR) |-> results.run_last, "end result not marked last of its byte")
    `GRSD_ASSERT(a_ready_idle, bytes.ready |-> state_reg == ST_IDLE, "byte taken outside idle")
    `GRSD_ASSERT(a_end_clear, state_reg == ST_END && !blocked |=> phase_reg == PH_HEADER && prev_key_reg == '1, "digest state not cleared after end")
    `GRSD_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid_reg && !pend_valid_reg, "result pending during reset")

endmodule

`default_nettype wire
